>>> hw/rtl/rrss_pkg.sv
`default_nettype none

package rrss_pkg;

  // Default number of entries in the ready queue.
  localparam int unsigned QueueDepth = 16;

  // Request codes and response kinds.
  localparam logic ReqArrival = 1'b0;
  localparam logic ReqTick    = 1'b1;
  localparam logic RespAck    = 1'b0;
  localparam logic RespSlot   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  task_id;
    logic [15:0] burst_len;
  } req_t;

  typedef struct packed {
    logic        resp_kind;
    logic [7:0]  run_id;
    logic        idle;
    logic        finished;
    logic [15:0] slot_index;
    logic        dropped;
    logic        stopped;
  } resp_t;

  // One queued task: id and remaining slots.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remain;
  } entry_t;

  // Per-cell control: take the neighbor's entry, or load the pushed entry.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrss_cell.sv
`default_nettype none

// One slot of the shifting ready queue.
module rrss_cell (
  input  wire                 clk_i,
  input  rrss_pkg::cell_ctrl_t ctrl_i,
  input  rrss_pkg::entry_t    push_entry_i,
  input  rrss_pkg::entry_t    neighbor_i,
  output rrss_pkg::entry_t    entry_o
);

  rrss_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = push_entry_i;
    end else if (ctrl_i.shift) begin
      entry_d = neighbor_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> hw/rtl/rrss_queue.sv
`default_nettype none

// Ready queue as a row of cells: the head sits in cell 0, a pop shifts every
// cell one step toward the head, a push loads the first free cell.
module rrss_queue #(
  parameter int unsigned DEPTH = rrss_pkg::QueueDepth,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               pop_i,
  input  wire               push_i,
  input  rrss_pkg::entry_t  push_entry_i,
  output rrss_pkg::entry_t  head_o,
  output logic [CntW-1:0]   count_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] wr_pos;
  rrss_pkg::entry_t cell_entry [DEPTH];

  // With a pop in the same cycle the free cell moves one step toward the head.
  assign wr_pos = pop_i ? (count_q - CntW'(1)) : count_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rrss_pkg::cell_ctrl_t ctrl;
    rrss_pkg::entry_t     neighbor;

    assign ctrl.shift = pop_i;
    assign ctrl.load  = push_i && (wr_pos == CntW'(i));

    if (i == DEPTH - 1) begin : g_last
      assign neighbor = '0;
    end else begin : g_mid
      assign neighbor = cell_entry[i+1];
    end

    rrss_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .push_entry_i (push_entry_i),
      .neighbor_i   (neighbor),
      .entry_o      (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = cell_entry[0];
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> hw/rtl/round_robin_slot_scheduler.sv
// Each accepted input word's result word is registered in the output register.
// Throughput: one word per cycle while the output side takes each result; the queue
//   can pop from the head cell and push into the cell row in the same cycle.
// Reset (rst_ni low, asynchronous): queue empty, no held task, slot counter zero,
//   slot_limit zero, output register empty. Queue cells are not cleared.
`default_nettype none

module round_robin_slot_scheduler #(
  parameter int unsigned QUEUE_DEPTH = rrss_pkg::QueueDepth
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  // Configuration: slot_limit
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire [15:0]       cfg_data_i,
  // Request channel
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  rrss_pkg::req_t   in_data_i,
  // Result channel
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output rrss_pkg::resp_t  out_data_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]      slot_limit_q;
  logic [15:0]      slot_count_q, slot_count_d;
  logic             held_valid_q, held_valid_d;
  rrss_pkg::entry_t held_task_q, held_task_d;
  logic             out_valid_q, out_valid_d;
  rrss_pkg::resp_t  out_data_q, out_data_d;

  logic             accept;
  logic             q_pop, q_push;
  rrss_pkg::entry_t q_push_entry, q_head;
  logic [CntW-1:0]  q_count;
  logic             q_full, q_empty;

  // Always taken; user must write configuration only when block idle; unenforced.
  assign cfg_ready_o = 1'b1;

  // Take a new word when the output register is empty or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign q_full  = (q_count == CntW'(QUEUE_DEPTH));
  assign q_empty = (q_count == '0);

  always_comb begin
    rrss_pkg::entry_t cur;
    logic             have;

    cur          = '0;
    have         = 1'b0;
    q_pop        = 1'b0;
    q_push       = 1'b0;
    q_push_entry = held_task_q;
    slot_count_d = slot_count_q;
    held_valid_d = held_valid_q;
    held_task_d  = held_task_q;
    out_data_d   = '0;

    if (in_data_i.req_type == rrss_pkg::ReqArrival) begin
      // Append the arriving task, or drop it when the queue is full.
      out_data_d.resp_kind = rrss_pkg::RespAck;
      q_push_entry.id      = in_data_i.task_id;
      q_push_entry.remain  = in_data_i.burst_len;
      out_data_d.dropped   = q_full;
      q_push               = !q_full;
    end else begin
      out_data_d.resp_kind  = rrss_pkg::RespSlot;
      out_data_d.slot_index = slot_count_q;
      if (slot_count_q >= slot_limit_q) begin
        // At or past the limit: report stop, hold all state.
        out_data_d.stopped = 1'b1;
      end else begin
        if (held_valid_q) begin
          // The preempted task rejoins the tail before the head is picked.
          have         = 1'b1;
          held_valid_d = 1'b0;
          if (q_empty) begin
            cur = held_task_q;
          end else begin
            cur    = q_head;
            q_pop  = 1'b1;
            q_push = 1'b1;
          end
        end else if (!q_empty) begin
          have  = 1'b1;
          cur   = q_head;
          q_pop = 1'b1;
        end

        if (!have) begin
          out_data_d.idle = 1'b1;
        end else begin
          out_data_d.run_id = cur.id;
          if (cur.remain <= 16'd1) begin
            out_data_d.finished = 1'b1;
          end else begin
            held_valid_d       = 1'b1;
            held_task_d.id     = cur.id;
            held_task_d.remain = cur.remain - 16'd1;
          end
        end
        slot_count_d = slot_count_q + 16'd1;
      end
    end

    // Nothing moves unless the word is actually taken.
    if (!accept) begin
      q_pop        = 1'b0;
      q_push       = 1'b0;
      slot_count_d = slot_count_q;
      held_valid_d = held_valid_q;
      held_task_d  = held_task_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  rrss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_i        (q_pop),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .head_o       (q_head),
    .count_o      (q_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= '0;
      slot_count_q <= '0;
      held_valid_q <= 1'b0;
      held_task_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        slot_limit_q <= cfg_data_i;
      end
      slot_count_q <= slot_count_d;
      held_valid_q <= held_valid_d;
      held_task_q  <= held_task_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload needs no reset; load it with each accepted word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> tb/sv/round_robin_slot_scheduler_tb.sv
`default_nettype none

module round_robin_slot_scheduler_tb;
  import rrss_pkg::*;

  // Clock, reset and block ports. Every input starts at a known value.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  resp_t       out_data_o;

  // Words waiting to be offered, and result words owed by the block.
  req_t  req_backlog[$];
  resp_t due_resps[$];

  // Idle percentages of the sender and of the receiver for the current phase.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // Shadow of the scheduler: ready queue, preempted task, slot counter, limit.
  entry_t      ready_fifo[$];
  logic        held_valid = 1'b0;
  entry_t      held_task  = '0;
  logic [15:0] slot_count = '0;
  logic [15:0] slot_limit = '0;

  // Run statistics.
  int words_sent   = 0;
  int mismatches   = 0;
  int cfg_writes   = 0;
  int n_reports    = 0;
  int n_idle       = 0;
  int n_finished   = 0;
  int n_stopped    = 0;
  int n_dropped    = 0;

  round_robin_slot_scheduler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Advance the shadow scheduler by one word and return the result word it owes.
  function automatic resp_t scheduler_next(req_t rq);
    resp_t  r;
    entry_t cur;
    logic   have;
    r         = '0;
    cur       = '0;
    have      = 1'b0;
    r.resp_kind = (rq.req_type == ReqTick) ? RespSlot : RespAck;

    // Arrival: append to the tail, or drop it when the queue is full.
    if (rq.req_type == ReqArrival) begin
      if (ready_fifo.size() >= QueueDepth) begin
        r.dropped = 1'b1;
        n_dropped++;
      end else begin
        ready_fifo.push_back({rq.task_id, rq.burst_len});
      end
      return r;
    end

    n_reports++;
    r.slot_index = slot_count;
    // At or past the limit: report stopped and change nothing.
    if (slot_count >= slot_limit) begin
      r.stopped = 1'b1;
      n_stopped++;
      return r;
    end

    // Requeue the task preempted at the last tick behind any new arrivals.
    // With an empty queue it runs again at once; with a full queue the pop
    // frees the cell that the push takes.
    if (held_valid) begin
      if (ready_fifo.size() == 0) begin
        cur = held_task;
      end else begin
        cur = ready_fifo.pop_front();
        ready_fifo.push_back(held_task);
      end
      have       = 1'b1;
      held_valid = 1'b0;
    end else if (ready_fifo.size() != 0) begin
      cur  = ready_fifo.pop_front();
      have = 1'b1;
    end

    if (!have) begin
      r.idle = 1'b1;
      n_idle++;
    end else begin
      r.run_id = cur.id;
      // A burst of one (or zero) ends in this slot; otherwise hold the rest.
      if (cur.remain <= 16'd1) begin
        r.finished = 1'b1;
        n_finished++;
      end else begin
        held_task  = {cur.id, cur.remain - 16'd1};
        held_valid = 1'b1;
      end
    end
    slot_count = slot_count + 16'd1;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: predict each accepted word, then offer the next one from the backlog.
  // Hold valid and payload steady until the word is taken.
  always @(posedge clk_i) begin : drv
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_resps.push_back(scheduler_next(in_data_i));
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= req_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result channel at random and compare each taken word
  // against the oldest owed result.
  always @(posedge clk_i) begin : mon
    resp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (due_resps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual %h",
                   $time, out_data_o);
        end else begin
          want = due_resps.pop_front();
          check_field("resp_kind",  want.resp_kind,  out_data_o.resp_kind);
          check_field("run_id",     want.run_id,     out_data_o.run_id);
          check_field("idle",       want.idle,       out_data_o.idle);
          check_field("finished",   want.finished,   out_data_o.finished);
          check_field("slot_index", want.slot_index, out_data_o.slot_index);
          check_field("dropped",    want.dropped,    out_data_o.dropped);
          check_field("stopped",    want.stopped,    out_data_o.stopped);
        end
      end
    end
  end

  task automatic add_word(input logic kind, input logic [7:0] id, input logic [15:0] burst);
    req_t w;
    w.req_type  = kind;
    w.task_id   = id;
    w.burst_len = burst;
    req_backlog.push_back(w);
  endtask

  // Random words in chunks of twenty, each chunk with its own tick share, so
  // the queue swings between full (drops) and empty (idle slots). Keep most
  // bursts short; a rare full-range burst lingers in the rotation.
  task automatic add_random_words(input int count);
    req_t w;
    int   tick_pct;
    tick_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) tick_pct = $urandom_range(90, 20);
      w.req_type  = ($urandom_range(99) < tick_pct) ? ReqTick : ReqArrival;
      w.task_id   = 8'($urandom_range(255));
      w.burst_len = ($urandom_range(63) == 0) ? 16'($urandom_range(65535, 1))
                                              : 16'($urandom_range(6, 1));
      req_backlog.push_back(w);
    end
  endtask

  // Wait until every word is offered, taken and answered, then let the
  // output register settle.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || due_resps.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Write slot_limit while the block is idle.
  task automatic write_slot_limit(input logic [15:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slot_limit = value;
    cfg_writes++;
  endtask

  initial begin : main
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Limit still at its reset value of zero: the first tick reports stopped.
    src_idle_pct   = 16;
    sink_stall_pct = 82;
    add_word(ReqTick, 8'd0, 16'd0);
    add_word(ReqArrival, 8'd0, 16'd1);
    wait_quiet();
    write_slot_limit(16'hFFFF);

    // Single-slot task finishes, then an idle slot.
    add_word(ReqTick, 8'd0, 16'd0);
    add_word(ReqTick, 8'd0, 16'd0);
    // Longest burst alternates with a two-slot task; later the long one runs
    // alone and is picked straight from the hold with the queue empty.
    add_word(ReqArrival, 8'hFF, 16'hFFFF);
    add_word(ReqArrival, 8'h5A, 16'd2);
    repeat (6) add_word(ReqTick, 8'd0, 16'd0);
    // Fill the queue behind the held task, overflow it by one, then tick with
    // a full queue and a held task.
    for (int i = 0; i < 17; i++) add_word(ReqArrival, 8'(8'h10 + i), 16'(1 + i % 3));
    add_word(ReqTick, 8'd0, 16'd0);
    wait_quiet();

    // Sender mostly busy, receiver mostly stalled; no limit in reach.
    add_random_words(350);
    wait_quiet();

    // Swap the idling and set the limit sixty slots ahead so it stops mid-phase.
    write_slot_limit(slot_count + 16'd60);
    src_idle_pct   = 82;
    sink_stall_pct = 16;
    add_random_words(350);
    wait_quiet();

    // Limit of zero: every tick is stopped, arrivals still queue or drop.
    write_slot_limit(16'd0);
    add_random_words(20);
    wait_quiet();

    // Full limit again, no idling on either side.
    write_slot_limit(16'hFFFF);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    add_random_words(330);
    wait_quiet();

    $display("Sent %0d words: %0d slot reports (%0d idle, %0d finished, %0d stopped), %0d drops",
             words_sent, n_reports, n_idle, n_finished, n_stopped, n_dropped);
    $display("slot_limit written %0d times, final slot %0d, %0d mismatches",
             cfg_writes, slot_count, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: the slowest run needs well under a tenth of this.
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
